FILE: src/cmf_pkg.sv
// Shared types and constants of the cross morphology filter.
`timescale 1ns / 1ps

package cmf_pkg;

    // Field widths
    localparam int PIXEL_W        = 8;
    localparam int MODE_W         = 1;
    localparam int LINE_WIDTH_W   = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    // Smallest frame size in either direction
    localparam int MIN_SIZE = 3;

    // Cells behind the line store read register: centre and left column
    localparam int WINDOW_CELLS = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_TARGET       = 3'd1,
        CFG_FILL         = 3'd2,
        CFG_LINE_WIDTH   = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_DILATE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_ERODE  = 1'b1;

    // Register reset values
    localparam logic [MODE_W-1:0]         MODE_RST         = MODE_DILATE;
    localparam logic [PIXEL_W-1:0]        TARGET_RST       = 8'd35;
    localparam logic [PIXEL_W-1:0]        FILL_RST         = 8'd46;
    localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd1024;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd4096;

    // Input word
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_in;
        logic               drain;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               line_end;
        logic               frame_end;
    } t_out_word;

endpackage

FILE: src/cmf_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
`timescale 1ns / 1ps

interface cmf_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cross_morphology_filter.sv
// Top level of the 4-neighbor cross morphology filter.
`timescale 1ns / 1ps

// Takes one pixel word per clock in raster order, unless the output stalls, and returns each
// pixel one line later, dilated or eroded against its left, right, upper and lower neighbors;
// border rows and columns pass unchanged. The line store has one write port and two registered
// read ports (upper line at the current column, middle line one column ahead), and a two-entry
// pipeline (the compute stage behind the read registers, then the output register) can take one
// more word while the consumer stalls; the input stalls once both entries hold a word and the
// consumer stalls. The middle-line read register feeds a row of two cells (centre, left) that
// shifts on every pixel. Drain words after the last pixel of a frame push out the last line,
// one pixel each. The line stores need no clearing after reset; a pixel of the first line of a
// frame gives no result.
module cross_morphology_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cmf_stream_if.sink                     i_pix,
    cmf_stream_if.source                   o_pix
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (cmf_pkg::LINE_WIDTH_W > WEFF_W) ? cmf_pkg::LINE_WIDTH_W : WEFF_W;
    localparam int HCMP_W = (cmf_pkg::FRAME_HEIGHT_W > HEFF_W) ?
                            cmf_pkg::FRAME_HEIGHT_W : HEFF_W;

    typedef struct packed {
        logic [cmf_pkg::PIXEL_W-1:0] down;
        logic                        drain;
        logic                        border;
        logic                        line_end;
        logic                        frame_end;
    } t_stage;

    // Configuration
    logic [cmf_pkg::MODE_W-1:0]         r_mode;
    logic [cmf_pkg::PIXEL_W-1:0]        r_target;
    logic [cmf_pkg::PIXEL_W-1:0]        r_fill;
    logic [cmf_pkg::LINE_WIDTH_W-1:0]   r_line_width;
    logic [cmf_pkg::FRAME_HEIGHT_W-1:0] r_frame_height;

    // Position and flush control
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_fcol, n_fcol;
    logic             r_flush, n_flush;

    // Pipeline
    logic                 r_s1_valid;
    t_stage               r_s1;
    t_stage               n_s1;
    logic                 n_s1_has;
    logic                 r_o_valid;
    cmf_pkg::t_out_word   r_o_word;

    logic [WEFF_W-1:0] eff_w;
    logic [HEFF_W-1:0] eff_h;
    logic [WCMP_W-1:0] lw_ext;
    logic [HCMP_W-1:0] fh_ext;
    logic              in_accept;
    logic              in_ready;
    logic              s1_adv;
    logic              is_drain;
    logic              last_col;
    logic              row_wrap;
    logic              flush_last;
    logic              pix_accept;
    logic              drain_read;

    logic [COL_W-1:0]            mid_addr;
    logic [cmf_pkg::PIXEL_W-1:0] up_rd;
    logic [cmf_pkg::PIXEL_W-1:0] mid_rd;
    logic [cmf_pkg::PIXEL_W-1:0] cell_in   [cmf_pkg::WINDOW_CELLS];
    logic [cmf_pkg::PIXEL_W-1:0] cell_code [cmf_pkg::WINDOW_CELLS];
    logic [cmf_pkg::PIXEL_W-1:0] s1_result;

    // Cross operation on one inner pixel; the centre code itself is never tested
    function automatic logic [cmf_pkg::PIXEL_W-1:0] f_cross(
        input logic [cmf_pkg::MODE_W-1:0]  mode,
        input logic [cmf_pkg::PIXEL_W-1:0] tgt,
        input logic [cmf_pkg::PIXEL_W-1:0] fill,
        input logic [cmf_pkg::PIXEL_W-1:0] centre,
        input logic [cmf_pkg::PIXEL_W-1:0] left,
        input logic [cmf_pkg::PIXEL_W-1:0] right,
        input logic [cmf_pkg::PIXEL_W-1:0] up,
        input logic [cmf_pkg::PIXEL_W-1:0] down
    );
        logic                        any_hit;
        logic                        all_hit;
        logic [cmf_pkg::PIXEL_W-1:0] res;
        any_hit = (left == tgt) || (right == tgt) || (up == tgt) || (down == tgt);
        all_hit = (left == tgt) && (right == tgt) && (up == tgt) && (down == tgt);
        if (mode == cmf_pkg::MODE_DILATE) begin
            res = any_hit ? tgt : centre;
        end else begin
            res = all_hit ? centre : fill;
        end
        return res;
    endfunction

    // Saturate the frame sizes into their legal range
    always_comb begin
        lw_ext = WCMP_W'(r_line_width);
        fh_ext = HCMP_W'(r_frame_height);
        if (lw_ext < WCMP_W'(cmf_pkg::MIN_SIZE)) begin
            eff_w = WEFF_W'(cmf_pkg::MIN_SIZE);
        end else if (lw_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_w = WEFF_W'(MAX_WIDTH);
        end else begin
            eff_w = WEFF_W'(lw_ext);
        end
        if (fh_ext < HCMP_W'(cmf_pkg::MIN_SIZE)) begin
            eff_h = HEFF_W'(cmf_pkg::MIN_SIZE);
        end else if (fh_ext > HCMP_W'(MAX_HEIGHT)) begin
            eff_h = HEFF_W'(MAX_HEIGHT);
        end else begin
            eff_h = HEFF_W'(fh_ext);
        end
    end

    // Handshake: stage 1 moves on when the output register is free or being emptied
    assign s1_adv     = !r_o_valid || o_pix.ready;
    assign in_ready   = !r_s1_valid || s1_adv;
    assign in_accept  = i_pix.valid && in_ready;
    assign is_drain   = i_pix.data.drain;
    assign pix_accept = in_accept && !is_drain;
    assign drain_read = in_accept && is_drain && r_flush;

    // Position flags of the incoming word
    assign last_col   = (WEFF_W'(r_in_col) + WEFF_W'(1)) >= eff_w;
    assign row_wrap   = (HEFF_W'(r_in_row) + HEFF_W'(1)) >= eff_h;
    assign flush_last = (WEFF_W'(r_fcol) + WEFF_W'(1)) >= eff_w;

    // Middle read: one column ahead, wrap to column 0 for the next line, or the flush column
    always_comb begin
        if (is_drain) begin
            mid_addr = r_fcol;
        end else if (last_col) begin
            mid_addr = '0;
        end else begin
            mid_addr = r_in_col + COL_W'(1);
        end
    end

    cmf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_we        (pix_accept),
        .i_waddr     (r_in_col),
        .i_wdata_up  (mid_rd),
        .i_wdata_mid (i_pix.data.pixel_in),
        .i_re_up     (pix_accept),
        .i_raddr_up  (r_in_col),
        .i_re_mid    (pix_accept || drain_read),
        .i_raddr_mid (mid_addr),
        .o_up        (up_rd),
        .o_mid       (mid_rd)
    );

    // Row of window cells: read register -> centre -> left
    for (genvar k = 0; k < cmf_pkg::WINDOW_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = mid_rd;
        end else begin : g_link
            assign cell_in[k] = cell_code[k-1];
        end
        cmf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (pix_accept),
            .i_code  (cell_in[k]),
            .o_code  (cell_code[k])
        );
    end

    // Next position, flush state and stage 1 contents
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_fcol   = r_fcol;
        n_flush  = r_flush;
        n_s1_has = 1'b0;
        n_s1     = '0;
        if (pix_accept) begin
            n_in_col = last_col ? '0 : r_in_col + COL_W'(1);
            if (last_col) begin
                n_in_row = row_wrap ? '0 : r_in_row + ROW_W'(1);
            end
            // a new pixel drops any pending flush; the last pixel of a frame arms one
            n_flush = last_col && row_wrap;
            n_fcol  = '0;
        end else if (drain_read) begin
            n_fcol  = flush_last ? '0 : r_fcol + COL_W'(1);
            n_flush = !flush_last;
        end
        if (is_drain) begin
            n_s1_has       = r_flush;
            n_s1.drain     = 1'b1;
            n_s1.border    = 1'b1;
            n_s1.line_end  = flush_last;
            n_s1.frame_end = flush_last;
        end else begin
            n_s1_has       = r_in_row != '0;
            n_s1.drain     = 1'b0;
            n_s1.border    = (r_in_row == ROW_W'(1)) || (r_in_col == '0) || last_col ||
                             (HEFF_W'(r_in_row) >= eff_h);
            n_s1.line_end  = last_col;
            n_s1.frame_end = 1'b0;
        end
        n_s1.down = i_pix.data.pixel_in;
    end

    // Stage 1 result from the read registers and the cells
    always_comb begin
        if (r_s1.drain) begin
            s1_result = mid_rd;
        end else if (r_s1.border) begin
            s1_result = cell_code[0];
        end else begin
            s1_result = f_cross(r_mode, r_target, r_fill, cell_code[0], cell_code[1],
                                mid_rd, up_rd, r_s1.down);
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= cmf_pkg::MODE_RST;
            r_target       <= cmf_pkg::TARGET_RST;
            r_fill         <= cmf_pkg::FILL_RST;
            r_line_width   <= cmf_pkg::LINE_WIDTH_RST;
            r_frame_height <= cmf_pkg::FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_fcol         <= '0;
            r_flush        <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cmf_pkg::CFG_MODE: begin
                        r_mode <= i_cfg_data[cmf_pkg::MODE_W-1:0];
                    end
                    cmf_pkg::CFG_TARGET: begin
                        r_target <= i_cfg_data[cmf_pkg::PIXEL_W-1:0];
                    end
                    cmf_pkg::CFG_FILL: begin
                        r_fill <= i_cfg_data[cmf_pkg::PIXEL_W-1:0];
                    end
                    cmf_pkg::CFG_LINE_WIDTH: begin
                        r_line_width <= i_cfg_data[cmf_pkg::LINE_WIDTH_W-1:0];
                    end
                    cmf_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[cmf_pkg::FRAME_HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_fcol   <= n_fcol;
            r_flush  <= n_flush;
            // advance stage 1, then load it from the accepted word
            if (in_accept) begin
                r_s1_valid <= n_s1_has;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_valid) begin
            r_o_word.pixel_out <= s1_result;
            r_o_word.line_end  <= r_s1.line_end;
            r_o_word.frame_end <= r_s1.frame_end;
        end
    end

    assign i_pix.ready = in_ready;
    assign o_pix.valid = r_o_valid;
    assign o_pix.data  = r_o_word;

    // A flush is only pending at the start of a frame
    a_flush_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_in_row == '0))
        else $error("flush pending outside the first input row");

    // A drain word with a flush pending always produces a result
    a_drain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_drain && r_flush) |=> r_s1_valid)
        else $error("drain word lost its flush result");

    // The end of a frame is always the end of a line
    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.data.frame_end) |-> o_pix.data.line_end)
        else $error("frame end without line end");

    // A result waiting in stage 1 behind a stalled output blocks new words
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !o_pix.ready) |=> r_s1_valid)
        else $error("stage 1 result dropped during output stall");

endmodule

FILE: src/cmf_line_store.sv
// Upper and middle line stores: one write port, registered reads.
`timescale 1ns / 1ps

module cmf_line_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [cmf_pkg::PIXEL_W-1:0] i_wdata_up,
    input  logic [cmf_pkg::PIXEL_W-1:0] i_wdata_mid,
    input  logic                        i_re_up,
    input  logic [ADDR_W-1:0]           i_raddr_up,
    input  logic                        i_re_mid,
    input  logic [ADDR_W-1:0]           i_raddr_mid,
    output logic [cmf_pkg::PIXEL_W-1:0] o_up,
    output logic [cmf_pkg::PIXEL_W-1:0] o_mid
);

    logic [cmf_pkg::PIXEL_W-1:0] r_upper  [DEPTH];
    logic [cmf_pkg::PIXEL_W-1:0] r_middle [DEPTH];
    logic [cmf_pkg::PIXEL_W-1:0] r_up_rd;
    logic [cmf_pkg::PIXEL_W-1:0] r_mid_rd;

    // Write both lines at the column of the incoming pixel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_upper[i_waddr]  <= i_wdata_up;
            r_middle[i_waddr] <= i_wdata_mid;
        end
    end

    // Read before write; hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_re_up) begin
            r_up_rd <= r_upper[i_raddr_up];
        end
        if (i_re_mid) begin
            r_mid_rd <= r_middle[i_raddr_mid];
        end
    end

    assign o_up  = r_up_rd;
    assign o_mid = r_mid_rd;

endmodule

FILE: src/cmf_cell.sv
// Window cell: holds one middle-line code and passes it on when shifted.
`timescale 1ns / 1ps

module cmf_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [cmf_pkg::PIXEL_W-1:0] i_code,
    output logic [cmf_pkg::PIXEL_W-1:0] o_code
);

    logic [cmf_pkg::PIXEL_W-1:0] r_code;

    // Take the neighbor's code on each pixel word
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_code <= i_code;
        end
    end

    assign o_code = r_code;

endmodule

FILE: test/cross_morphology_filter_checker.sv
// Checker of the cross morphology filter: predicts every output word and compares it.
`timescale 1ns / 1ps

module cross_morphology_filter_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  cmf_pkg::t_in_word              i_pix_data,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  cmf_pkg::t_out_word             i_res_data,
    output int unsigned                    o_pending,
    output int unsigned                    o_fail_count
);

    // Shadow copy of the configuration registers
    logic [cmf_pkg::MODE_W-1:0]         cfg_mode;
    logic [cmf_pkg::PIXEL_W-1:0]        cfg_target;
    logic [cmf_pkg::PIXEL_W-1:0]        cfg_fill;
    logic [cmf_pkg::LINE_WIDTH_W-1:0]   cfg_line_width;
    logic [cmf_pkg::FRAME_HEIGHT_W-1:0] cfg_frame_height;

    // Predicted filter state: two line stores, the left neighbor and the raster positions
    logic [cmf_pkg::PIXEL_W-1:0] upper_row [MAX_WIDTH];
    logic [cmf_pkg::PIXEL_W-1:0] middle_row [MAX_WIDTH];
    logic [cmf_pkg::PIXEL_W-1:0] left_pixel;
    int unsigned                 in_col;
    int unsigned                 in_row;
    int unsigned                 out_col;
    int unsigned                 out_row;

    cmf_pkg::t_out_word expected_pixels [$];
    int unsigned        fail_count;
    int unsigned        result_index;
    int unsigned        pending_count;

    assign o_pending    = pending_count;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // Append one predicted word at the tail of the queue
    task automatic queue_expected(input cmf_pkg::t_out_word res);
        expected_pixels = {expected_pixels, res};
    endtask

    function automatic int unsigned clamp_size(input int unsigned val, input int unsigned hi);
        if (val < cmf_pkg::MIN_SIZE) return cmf_pkg::MIN_SIZE;
        if (val > hi) return hi;
        return val;
    endfunction

    // Dilate grows the target into the cross; erode keeps a pixel only inside a full cross
    function automatic logic [cmf_pkg::PIXEL_W-1:0] cross_result(
        input logic [cmf_pkg::PIXEL_W-1:0] centre,
        input logic [cmf_pkg::PIXEL_W-1:0] lft,
        input logic [cmf_pkg::PIXEL_W-1:0] rgt,
        input logic [cmf_pkg::PIXEL_W-1:0] upp,
        input logic [cmf_pkg::PIXEL_W-1:0] dwn
    );
        logic any_hit;
        logic all_hit;
        any_hit = (lft == cfg_target) || (rgt == cfg_target) ||
                  (upp == cfg_target) || (dwn == cfg_target);
        all_hit = (lft == cfg_target) && (rgt == cfg_target) &&
                  (upp == cfg_target) && (dwn == cfg_target);
        if (cfg_mode == cmf_pkg::MODE_DILATE) return any_hit ? cfg_target : centre;
        return all_hit ? centre : cfg_fill;
    endfunction

    task automatic reset_filter_state();
        cfg_mode         = cmf_pkg::MODE_RST;
        cfg_target       = cmf_pkg::TARGET_RST;
        cfg_fill         = cmf_pkg::FILL_RST;
        cfg_line_width   = cmf_pkg::LINE_WIDTH_RST;
        cfg_frame_height = cmf_pkg::FRAME_HEIGHT_RST;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        left_pixel = '0;
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        expected_pixels.delete();
    endtask

    task automatic write_register(input logic [cmf_pkg::CFG_IDX_W-1:0]  idx,
                                  input logic [cmf_pkg::CFG_DATA_W-1:0] val);
        case (cmf_pkg::t_cfg_idx'(idx))
            cmf_pkg::CFG_MODE:         cfg_mode         = val[cmf_pkg::MODE_W-1:0];
            cmf_pkg::CFG_TARGET:       cfg_target       = val[cmf_pkg::PIXEL_W-1:0];
            cmf_pkg::CFG_FILL:         cfg_fill         = val[cmf_pkg::PIXEL_W-1:0];
            cmf_pkg::CFG_LINE_WIDTH:   cfg_line_width   = val[cmf_pkg::LINE_WIDTH_W-1:0];
            cmf_pkg::CFG_FRAME_HEIGHT: cfg_frame_height = val[cmf_pkg::FRAME_HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // Advance the filter by one input word and queue the output word it releases, if any
    task automatic predict_filtered_pixel(input cmf_pkg::t_in_word word);
        int unsigned                 w_eff;
        int unsigned                 h_eff;
        int unsigned                 col;
        int unsigned                 orow;
        logic [cmf_pkg::PIXEL_W-1:0] ctr;
        logic [cmf_pkg::PIXEL_W-1:0] rgt;
        logic [cmf_pkg::PIXEL_W-1:0] upp;
        logic                        last_col;
        logic                        border;
        cmf_pkg::t_out_word          res;

        w_eff = clamp_size(32'(cfg_line_width), MAX_WIDTH);
        h_eff = clamp_size(32'(cfg_frame_height), MAX_HEIGHT);

        // Drain: push out one pixel of the last line, passed through as a border row
        if (word.drain) begin
            if (in_row != 0 || (out_row == 0 && out_col == 0)) return;
            col = (out_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : out_col;
            last_col = (col + 1 >= w_eff);
            res.pixel_out = middle_row[col];
            res.line_end  = last_col;
            res.frame_end = last_col;
            queue_expected(res);
            if (last_col) begin
                out_col = 0;
                out_row = 0;
            end else begin
                out_col = col + 1;
            end
            return;
        end

        col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
        ctr = middle_row[col];
        rgt = (col + 1 < MAX_WIDTH) ? middle_row[col + 1] : '0;
        upp = upper_row[col];

        // First line of a frame releases nothing and cancels a pending flush
        if (in_row == 0) begin
            out_row = 0;
            out_col = 0;
        end else begin
            orow     = in_row - 1;
            last_col = (col + 1 >= w_eff);
            border   = (orow == 0) || (col == 0) || last_col || (orow + 1 >= h_eff);
            res.pixel_out = border ? ctr : cross_result(ctr, left_pixel, rgt, upp, word.pixel_in);
            res.line_end  = last_col;
            res.frame_end = 1'b0;
            queue_expected(res);
            if (last_col) begin
                out_col = 0;
                out_row = in_row;
            end else begin
                out_col = col + 1;
                out_row = orow;
            end
        end

        // Shift the line stores and advance the input position
        left_pixel      = ctr;
        upper_row[col]  = ctr;
        middle_row[col] = word.pixel_in;
        if (col + 1 >= w_eff) begin
            in_col     = 0;
            left_pixel = '0;
            in_row     = (in_row + 1 >= h_eff) ? 0 : in_row + 1;
        end else begin
            in_col = col + 1;
        end
    endtask

    task automatic check_result(input cmf_pkg::t_out_word got);
        cmf_pkg::t_out_word want;
        result_index++;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("word %0d (pixel %0d) arrived with nothing expected",
                                      result_index, got.pixel_out));
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("word %0d pixel_out %0d, expected %0d",
                                      result_index, got.pixel_out, want.pixel_out));
        if (got.line_end !== want.line_end)
            report_mismatch($sformatf("word %0d line_end %0b, expected %0b",
                                      result_index, got.line_end, want.line_end));
        if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("word %0d frame_end %0b, expected %0b",
                                      result_index, got.frame_end, want.frame_end));
    endtask

    initial begin
        fail_count    = 0;
        result_index  = 0;
        pending_count = 0;
    end

    // Check output words before the input word of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_filter_state();
        end else begin
            if (i_res_valid && i_res_ready) check_result(i_res_data);
            if (i_cfg_we) write_register(i_cfg_idx, i_cfg_data);
            if (i_pix_valid && i_pix_ready) predict_filtered_pixel(i_pix_data);
        end
        pending_count = expected_pixels.size();
    end

endmodule

FILE: test/cross_morphology_filter_test.sv
// Testbench top of the cross morphology filter: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module cross_morphology_filter_test;

    localparam int          MAX_W          = 1024;
    localparam int          MAX_H          = 4096;
    localparam int          PX_W           = cmf_pkg::PIXEL_W;
    localparam int          MD_W           = cmf_pkg::MODE_W;
    localparam int          CD_W           = cmf_pkg::CFG_DATA_W;
    localparam int          RESET_CYCLES   = 7;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          END_CYCLES     = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PIXELS  = 720;
    localparam int unsigned CALM_PIXELS    = 120;

    // Directed images, raster order, 3 x 3
    localparam logic [0:8][7:0] DILATE_IMG = {
        8'd0, 8'd255, 8'd0,
        8'd7, 8'd0,   8'd9,
        8'd0, 8'd0,   8'd0
    };
    localparam logic [0:8][7:0] ERODE_IMG = {
        8'd9, 8'd0,   8'd9,
        8'd0, 8'd128, 8'd0,
        8'd9, 8'd0,   8'd9
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [cmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cmf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cmf_stream_if #(.t_word(cmf_pkg::t_in_word))  pix_in_if ();
    cmf_stream_if #(.t_word(cmf_pkg::t_out_word)) pix_out_if ();

    int unsigned                 pending;
    int unsigned                 fail_count;
    int unsigned                 quiet_cycles = 0;
    int unsigned                 random_pixels;
    int unsigned                 stall_left;
    int unsigned                 sink_calm_left;
    int unsigned                 src_calm_left;
    bit                          idle_en;
    logic [cmf_pkg::PIXEL_W-1:0] set_target;
    int unsigned                 width_eff;
    int unsigned                 height_eff;

    cross_morphology_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_if),
        .o_pix      (pix_out_if)
    );

    cross_morphology_filter_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (pix_in_if.valid),
        .i_pix_ready  (pix_in_if.ready),
        .i_pix_data   (pix_in_if.data),
        .i_res_valid  (pix_out_if.valid),
        .i_res_ready  (pix_out_if.ready),
        .i_res_data   (pix_out_if.data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // End the run when no word has moved on either channel for too long
    always @(posedge i_clk) begin
        if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** cross_morphology_filter: FAILED **");
            $finish;
        end
    end

    // Output side: random stall bursts, calm stretches in between
    initial begin
        pix_out_if.ready = 1'b0;
        stall_left       = 0;
        sink_calm_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                pix_out_if.ready <= 1'b0;
            end else if (idle_en && sink_calm_left == 0 && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 18);
                pix_out_if.ready <= 1'b0;
            end else begin
                if (sink_calm_left != 0) sink_calm_left--;
                else if ($urandom_range(0, 99) == 0) sink_calm_left = $urandom_range(20, 120);
                pix_out_if.ready <= 1'b1;
            end
        end
    end

    function automatic int unsigned clamp_size(input int unsigned val, input int unsigned hi);
        if (val < cmf_pkg::MIN_SIZE) return cmf_pkg::MIN_SIZE;
        if (val > hi) return hi;
        return val;
    endfunction

    function automatic logic [cmf_pkg::PIXEL_W-1:0] pick_pixel(input int unsigned target_pct);
        if ($urandom_range(0, 99) < target_pct) return set_target;
        return PX_W'($urandom_range(0, 255));
    endfunction

    // Offer one word, with an occasional gap first, and hold it until accepted
    task automatic send_word(input logic [cmf_pkg::PIXEL_W-1:0] px, input logic drn);
        cmf_pkg::t_in_word word;
        int unsigned       gap;
        if (idle_en && src_calm_left == 0 && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else if (src_calm_left != 0) begin
            src_calm_left--;
        end else if ($urandom_range(0, 99) == 0) begin
            src_calm_left = $urandom_range(20, 120);
        end
        word.pixel_in = px;
        word.drain    = drn;
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= word;
        @(posedge i_clk);
        while (!pix_in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!drn) random_pixels++;
    endtask

    // Hold the input until every expected word has come out
    task automatic hold_until_drained();
        pix_in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input cmf_pkg::t_cfg_idx idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CD_W'(val);
        @(negedge i_clk);
    endtask

    task automatic set_config(
        input logic [cmf_pkg::MODE_W-1:0]  mode,
        input logic [cmf_pkg::PIXEL_W-1:0] target,
        input logic [cmf_pkg::PIXEL_W-1:0] fill,
        input int unsigned                 width_field,
        input int unsigned                 height_field
    );
        write_reg(cmf_pkg::CFG_MODE, mode);
        write_reg(cmf_pkg::CFG_TARGET, target);
        write_reg(cmf_pkg::CFG_FILL, fill);
        write_reg(cmf_pkg::CFG_LINE_WIDTH, width_field);
        write_reg(cmf_pkg::CFG_FRAME_HEIGHT, height_field);
        i_cfg_we <= 1'b0;
        set_target = target;
        width_eff  = clamp_size(width_field, MAX_W);
        height_eff = clamp_size(height_field, MAX_H);
    endtask

    // Send whole lines, then the given number of drain words; noisy adds stray drains and holds
    task automatic run_frame(
        input int unsigned rows,
        input int unsigned flush_drains,
        input int unsigned target_pct,
        input bit          noisy
    );
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < width_eff; c++) begin
                if (noisy && $urandom_range(0, 19) == 0)
                    send_word(PX_W'($urandom_range(0, 255)), 1'b1);
                if (noisy && $urandom_range(0, 149) == 0)
                    hold_until_drained();
                send_word(pick_pixel(target_pct), 1'b0);
            end
        end
        repeat (flush_drains) send_word(PX_W'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin : stimulus
        logic [cmf_pkg::MODE_W-1:0]  mode;
        logic [cmf_pkg::PIXEL_W-1:0] target;
        logic [cmf_pkg::PIXEL_W-1:0] fill;
        int unsigned                 width_field;
        int unsigned                 height_field;
        int unsigned                 frames;
        int unsigned                 drains;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = cmf_pkg::CFG_MODE;
        i_cfg_data      = '0;
        pix_in_if.valid = 1'b0;
        pix_in_if.data  = '0;
        idle_en         = 1'b1;
        random_pixels   = 0;
        src_calm_left   = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Dilation, sizes below the minimum: the inner pixel has the target above it
        set_config(cmf_pkg::MODE_DILATE, 8'd255, 8'd0, 0, 2);
        for (int k = 0; k < 9; k++) send_word(DILATE_IMG[k], 1'b0);
        // Flush the last line, then one drain with nothing left to push out
        repeat (4) send_word(PX_W'($urandom_range(0, 255)), 1'b1);
        settle();

        // Erosion: the inner pixel sits in a full cross of target pixels and is kept
        set_config(cmf_pkg::MODE_ERODE, 8'd0, 8'd255, 3, 3);
        for (int k = 0; k < 9; k++) send_word(ERODE_IMG[k], 1'b0);
        repeat (3) send_word(PX_W'($urandom_range(0, 255)), 1'b1);
        settle();

        // Tallest frame (height saturates), cut short by lowering the height between lines
        mode   = MD_W'($urandom_range(0, 1));
        target = PX_W'($urandom_range(0, 255));
        fill   = PX_W'($urandom_range(0, 255));
        set_config(mode, target, fill, 1, 8191);
        run_frame(4, 0, 60, 1'b0);
        settle();
        set_config(mode, target, fill, 1, 5);
        run_frame(1, 3, 60, 1'b0);
        settle();

        // Random phases of small frames; the tail runs without any idling
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if (random_pixels + CALM_PIXELS >= RANDOM_PIXELS) idle_en = 1'b0;
            mode         = MD_W'($urandom_range(0, 1));
            target       = PX_W'($urandom_range(0, 255));
            fill         = ($urandom_range(0, 3) == 0) ? target : PX_W'($urandom_range(0, 255));
            width_field  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            height_field = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_config(mode, target, fill, width_field, height_field);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                // Every frame but the last may be cut off partway through its flush
                if (f + 1 == frames || $urandom_range(0, 3) != 0)
                    drains = width_eff + $urandom_range(0, 2);
                else
                    drains = $urandom_range(0, width_eff - 1);
                run_frame(height_eff, drains, $urandom_range(0, 4) * 25, 1'b1);
            end
            settle();
        end

        hold_until_drained();
        repeat (END_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** cross_morphology_filter: PASSED **");
        end else begin
            $display("** cross_morphology_filter: FAILED **");
        end
        $finish;
    end

endmodule
